### hdl/mcpt_pkg.sv
package mcpt_pkg;

	localparam int SLOT_COUNT_DEF    = 64;
	localparam int TICK_DIVISOR_DEF  = 10;
	localparam int INTERVAL_BITS_DEF = 24;

	localparam int REQ_W    = 3;
	localparam int SLOT_W   = 6;
	localparam int KIND_W   = 2;
	localparam int PERIOD_W = 21;

	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_START   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_STOP    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET     = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd5;

	localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;

	typedef struct packed {
		logic capture;
		logic do_tick;
		logic do_create;
		logic do_exec;
		logic do_flush;
	} cmd_t;

	typedef struct packed {
		logic step_ok;
		logic last_slot;
	} sts_t;

endpackage

### hdl/mcpt_ctrl.sv
module mcpt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [mcpt_pkg::REQ_W-1:0] req_type,
	input  mcpt_pkg::sts_t             sts,
	output mcpt_pkg::cmd_t             cmd
);
	import mcpt_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TICK   = 3'd1;
	localparam logic [2:0] ST_CREATE = 3'd2;
	localparam logic [2:0] ST_EXEC   = 3'd3;
	localparam logic [2:0] ST_FLUSH  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_TICK:   state_d = ST_TICK;
						REQ_CREATE: state_d = ST_CREATE;
						default:    state_d = ST_EXEC;
					endcase
				end
			end
			ST_TICK: begin
				if (sts.step_ok && sts.last_slot) state_d = ST_FLUSH;
			end
			ST_CREATE: begin
				if (sts.step_ok) state_d = ST_IDLE;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (sts.step_ok) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.capture   = accept;
	assign cmd.do_tick   = (state_q == ST_TICK);
	assign cmd.do_create = (state_q == ST_CREATE);
	assign cmd.do_exec   = (state_q == ST_EXEC);
	assign cmd.do_flush  = (state_q == ST_FLUSH);

endmodule

### hdl/mcpt_dp.sv
module mcpt_dp #(
	parameter int SLOT_COUNT    = mcpt_pkg::SLOT_COUNT_DEF,
	parameter int TICK_DIVISOR  = mcpt_pkg::TICK_DIVISOR_DEF,
	parameter int INTERVAL_BITS = mcpt_pkg::INTERVAL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcpt_pkg::cmd_t              cmd,
	output mcpt_pkg::sts_t              sts,
	input  logic [mcpt_pkg::REQ_W-1:0]  req_type,
	input  logic [mcpt_pkg::SLOT_W-1:0] slot,
	input  logic [INTERVAL_BITS-1:0]    interval_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mcpt_pkg::KIND_W-1:0] result_kind,
	output logic [mcpt_pkg::SLOT_W-1:0] result_slot,
	output logic                        last
);
	import mcpt_pkg::*;

	localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int DIV_SHIFT = INTERVAL_BITS + $clog2(TICK_DIVISOR);
	localparam int MULT_W    = INTERVAL_BITS + 1;
	localparam int PROD_W    = 2 * INTERVAL_BITS + 1;
	localparam logic [63:0] DIV_MULT_W =
		((64'd1 << DIV_SHIFT) + 64'(TICK_DIVISOR) - 64'd1) / 64'(TICK_DIVISOR);
	localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_W[MULT_W-1:0];
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	logic [REQ_W-1:0]    req_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PROD_W-1:0]   prod_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic [SLOT_COUNT-1:0] armed_q;
	logic                pend_valid_q;
	logic [IDX_W-1:0]    pend_slot_q;
	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_last_q;
	logic [PERIOD_W-1:0] rd_period_q;
	logic [PERIOD_W-1:0] rd_phase_q;
	logic [PERIOD_W-1:0] per_mem [SLOT_COUNT];
	logic [PERIOD_W-1:0] ph_mem [SLOT_COUNT];

	logic [INTERVAL_BITS-1:0] quo;
	logic [PERIOD_W-1:0] new_period;
	logic [PERIOD_W-1:0] ph_next;
	logic                cur_used;
	logic                cur_active;
	logic                fire;
	logic                out_free;
	logic                last_slot;
	logic                tick_push;
	logic                tick_ok;
	logic                tick_go;
	logic                create_emit;
	logic                create_ok;
	logic                create_go;
	logic                flush_ok;
	logic [IDX_W-1:0]    slot_idx;
	logic                exec_go;
	logic                push;
	logic [KIND_W-1:0]   push_kind;
	logic [IDX_W-1:0]    push_slot;
	logic                push_last;
	logic [IDX_W-1:0]    wr_addr;
	logic [IDX_W-1:0]    rd_addr;
	logic                per_we;
	logic                ph_we;
	logic [PERIOD_W-1:0] ph_wdata;

	// ticks from milliseconds, reciprocal multiply then clamp
	assign quo = INTERVAL_BITS'(prod_q >> DIV_SHIFT);

	always_comb begin
		if (quo == '0) begin
			new_period = PERIOD_W'(1);
		end else if (32'(quo) > 32'(PERIOD_MAX)) begin
			new_period = PERIOD_MAX;
		end else begin
			new_period = PERIOD_W'(quo);
		end
	end

	assign cur_used    = used_q[idx_q];
	assign cur_active  = cur_used && armed_q[idx_q];
	assign ph_next     = rd_phase_q + PERIOD_W'(1);
	assign fire        = (ph_next >= rd_period_q);
	assign out_free    = !out_valid_q || !out_stall;
	assign last_slot   = (idx_q == IDX_LAST);

	assign tick_push   = cur_active && fire && pend_valid_q;
	assign tick_ok     = !tick_push || out_free;
	assign tick_go     = cmd.do_tick && tick_ok;
	assign create_emit = !cur_used || last_slot;
	assign create_ok   = create_emit && out_free;
	assign create_go   = cmd.do_create && create_ok;
	assign flush_ok    = !pend_valid_q || out_free;

	assign slot_idx = IDX_W'(slot_q);
	assign exec_go  = cmd.do_exec && (32'(slot_q) < 32'(SLOT_COUNT)) && used_q[slot_idx];

	always_comb begin
		if (cmd.do_tick) begin
			sts.step_ok = tick_ok;
		end else if (cmd.do_create) begin
			sts.step_ok = create_ok;
		end else if (cmd.do_flush) begin
			sts.step_ok = flush_ok;
		end else begin
			sts.step_ok = 1'b1;
		end
		sts.last_slot = last_slot;
	end

	// result beat selection; the last firing of a tick waits for the flush
	always_comb begin
		push      = 1'b0;
		push_kind = KIND_FIRED;
		push_slot = pend_slot_q;
		push_last = 1'b0;
		if (tick_go && tick_push) begin
			push = 1'b1;
		end
		if (create_go) begin
			push      = 1'b1;
			push_kind = cur_used ? KIND_FULL : KIND_CREATED;
			push_slot = cur_used ? '0 : idx_q;
			push_last = 1'b1;
		end
		if (cmd.do_flush && flush_ok && pend_valid_q) begin
			push      = 1'b1;
			push_last = 1'b1;
		end
	end

	always_comb begin
		wr_addr  = idx_q;
		per_we   = 1'b0;
		ph_we    = 1'b0;
		ph_wdata = '0;
		if (tick_go && cur_active) begin
			ph_we    = 1'b1;
			ph_wdata = fire ? '0 : ph_next;
		end
		if (create_go && !cur_used) begin
			per_we = 1'b1;
			ph_we  = 1'b1;
		end
		if (exec_go) begin
			wr_addr = slot_idx;
			case (req_q)
				REQ_STOP, REQ_DESTROY: begin
					ph_we = 1'b1;
				end
				REQ_SET: begin
					per_we = 1'b1;
					ph_we  = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (tick_go) begin
			rd_addr = last_slot ? '0 : idx_q + IDX_W'(1);
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (per_we) per_mem[wr_addr] <= new_period;
		if (ph_we) ph_mem[wr_addr] <= ph_wdata;
		rd_period_q <= per_mem[rd_addr];
		rd_phase_q  <= ph_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			slot_q <= slot;
			prod_q <= PROD_W'(interval_ms) * PROD_W'(DIV_MULT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			used_q       <= '0;
			armed_q      <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (tick_go) begin
				idx_q <= last_slot ? '0 : idx_q + IDX_W'(1);
			end else if (cmd.do_create) begin
				if (create_ok) begin
					idx_q <= '0;
				end else if (!create_emit) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end

			if (create_go && !cur_used) begin
				used_q[idx_q]  <= 1'b1;
				armed_q[idx_q] <= 1'b0;
			end
			if (exec_go) begin
				case (req_q)
					REQ_START: armed_q[slot_idx] <= 1'b1;
					REQ_STOP:  armed_q[slot_idx] <= 1'b0;
					REQ_SET:   armed_q[slot_idx] <= 1'b1;
					REQ_DESTROY: begin
						armed_q[slot_idx] <= 1'b0;
						used_q[slot_idx]  <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			if (tick_go && cur_active && fire) begin
				pend_valid_q <= 1'b1;
				pend_slot_q  <= idx_q;
			end else if (cmd.do_flush && flush_ok) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_kind_q <= push_kind;
			out_slot_q <= SLOT_W'(push_slot);
			out_last_q <= push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign result_slot = out_slot_q;
	assign last        = out_last_q;

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.do_tick && !cmd.do_create) |-> (idx_q == '0))
		else $error("slot index not parked at zero outside a walk");

	a_armed_used: assert property (@(posedge clk) disable iff (!arst_n)
		((armed_q & ~used_q) == '0))
		else $error("armed slot that is not in use");

	a_pend_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (cmd.do_tick || cmd.do_flush))
		else $error("pending firing left over after a tick");

	a_create_claim: assert property (@(posedge clk) disable iff (!arst_n)
		(create_go && !cur_used) |=> used_q[$past(idx_q)])
		else $error("created slot not marked in use");

endmodule

### hdl/multi_channel_periodic_timer_top.sv
// channel  dir  handshake          beat fields
// in       in   in_valid/in_stall  req_type, slot, interval_ms
// out      out  out_valid/out_stall result_kind, result_slot, last
//
// a tick walks one slot per cycle through the period and phase memories, unless out_stall holds the walk
// a create scans one slot per cycle unless out_stall holds it; other requests pass through the exec state
// reset clears the in-use and armed flags at once, no clearing pass
// out_stall holds a walk only when a beat is ready and the result register is still full
module multi_channel_periodic_timer_top #(
	parameter int SLOT_COUNT    = mcpt_pkg::SLOT_COUNT_DEF,
	parameter int TICK_DIVISOR  = mcpt_pkg::TICK_DIVISOR_DEF,
	parameter int INTERVAL_BITS = mcpt_pkg::INTERVAL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mcpt_pkg::REQ_W-1:0]  req_type,
	input  logic [mcpt_pkg::SLOT_W-1:0] slot,
	input  logic [INTERVAL_BITS-1:0]    interval_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mcpt_pkg::KIND_W-1:0] result_kind,
	output logic [mcpt_pkg::SLOT_W-1:0] result_slot,
	output logic                        last
);
	import mcpt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mcpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcpt_dp #(
		.SLOT_COUNT    (SLOT_COUNT),
		.TICK_DIVISOR  (TICK_DIVISOR),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.slot        (slot),
		.interval_ms (interval_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.result_slot (result_slot),
		.last        (last)
	);

endmodule
